// ----- src/twp_pkg.sv -----
// Shared types, codes and a helper function for the pager wrap tracker.
`timescale 1ns / 1ps
package twp_pkg;

    localparam int TAB_STOP_DEF = 8;

    localparam logic [1:0] CFG_PAGE_LINES  = 2'd0;
    localparam logic [1:0] CFG_SCREEN_COLS = 2'd1;
    localparam logic [1:0] CFG_PAGING_ON   = 2'd2;

    localparam logic [1:0] KIND_ECHO   = 2'd0;
    localparam logic [1:0] KIND_PROMPT = 2'd1;
    localparam logic [1:0] KIND_DROP   = 2'd2;

    localparam logic [1:0] CHOICE_FULL  = 2'd0;
    localparam logic [1:0] CHOICE_SHORT = 2'd1;
    localparam logic [1:0] CHOICE_MINI  = 2'd2;
    localparam logic [1:0] CHOICE_TINY  = 2'd3;

    localparam logic [4:0] LEN_FULL  = 5'd29;
    localparam logic [4:0] LEN_SHORT = 5'd17;
    localparam logic [4:0] LEN_MINI  = 5'd8;
    localparam logic [4:0] LEN_TINY  = 5'd1;

    localparam logic [7:0] CODE_TAB   = 8'd9;
    localparam logic [7:0] CODE_LF    = 8'd10;
    localparam logic [7:0] CODE_CR    = 8'd13;
    localparam logic [7:0] CODE_SPACE = 8'd32;
    localparam logic [7:0] CODE_DEL   = 8'd127;
    localparam logic [7:0] CODE_Q_LO  = 8'h71;
    localparam logic [7:0] CODE_Q_UP  = 8'h51;

    localparam logic [7:0] COLS_DEFAULT = 8'd80;

    typedef struct packed {
        logic [7:0] page_lines;
        logic [7:0] screen_cols;
        logic       paging_on;
    } t_cfg;

    typedef struct packed {
        logic [7:0] a;
        logic [7:0] b;
        logic       sub;
    } t_alu_req;

    typedef struct packed {
        logic [7:0] sum;
        logic       carry;
    } t_alu_rsp;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] echo_code;
        logic [1:0] choice;
        logic [4:0] len;
    } t_result;

    typedef struct packed {
        logic [1:0] choice;
        logic [4:0] len;
    } t_prompt;

    // longest prompt text that fits one short of the width
    function automatic t_prompt prompt_fit(input logic [7:0] cols);
        logic [7:0] w;
        t_prompt    p;
        w = (cols == 8'd0) ? COLS_DEFAULT : cols;
        if (w > 8'd1) begin
            w = w - 8'd1;
        end
        if (w >= 8'(LEN_FULL)) begin
            p = '{choice: CHOICE_FULL, len: LEN_FULL};
        end else if (w >= 8'(LEN_SHORT)) begin
            p = '{choice: CHOICE_SHORT, len: LEN_SHORT};
        end else if (w >= 8'(LEN_MINI)) begin
            p = '{choice: CHOICE_MINI, len: LEN_MINI};
        end else begin
            p = '{choice: CHOICE_TINY, len: LEN_TINY};
        end
        return p;
    endfunction

endpackage

// ----- src/twp_req_if.sv -----
// Request channel carrying output bytes and prompt keys.
`timescale 1ns / 1ps
interface twp_req_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] byte_code;

    modport source (output valid, output action, output byte_code, input ready);
    modport sink   (input valid, input action, input byte_code, output ready);
endinterface

// ----- src/twp_rsp_if.sv -----
// Result channel carrying echo, prompt and drop results.
`timescale 1ns / 1ps
interface twp_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] echo_code;
    logic [1:0] prompt_choice;
    logic [4:0] prompt_chars;
    logic       last;

    modport source (output valid, output kind, output echo_code, output prompt_choice,
                    output prompt_chars, output last, input ready);
    modport sink   (input valid, input kind, input echo_code, input prompt_choice,
                    input prompt_chars, input last, output ready);
endinterface

// ----- src/twp_alu.sv -----
// Shared 8-bit add/subtract unit with carry out.
`timescale 1ns / 1ps
module twp_alu (
    input  twp_pkg::t_alu_req i_req,
    output twp_pkg::t_alu_rsp o_rsp
);
    import twp_pkg::*;

    logic [8:0] full;

    always_comb begin
        full = {1'b0, i_req.a} + {1'b0, (i_req.sub ? ~i_req.b : i_req.b)} + 9'(i_req.sub);
        o_rsp.sum   = full[7:0];
        o_rsp.carry = full[8];
    end
endmodule

// ----- src/twp_seq.sv -----
// Sequencer holding cursor and page state; drives the shared adder step by step.
`timescale 1ns / 1ps
module twp_seq #(
    parameter int TAB_STOP = twp_pkg::TAB_STOP_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  twp_pkg::t_cfg     i_cfg,
    twp_req_if.sink           i_req,
    twp_rsp_if.source         o_rsp,
    output twp_pkg::t_alu_req o_alu,
    input  twp_pkg::t_alu_rsp i_alu
);
    import twp_pkg::*;

    localparam int CW      = $clog2(TAB_STOP + 1);
    localparam int TAB_SH  = 8 + $clog2(TAB_STOP);
    localparam int TAB_MUL = ((1 << TAB_SH) + TAB_STOP - 1) / TAB_STOP;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_LA    = 8'b0000_0010,
        S_LB    = 8'b0000_0100,
        S_CELLS = 8'b0000_1000,
        S_W0    = 8'b0001_0000,
        S_W2    = 8'b0010_0000,
        S_W3    = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } t_state;

    typedef enum logic [1:0] {
        RET_LINE = 2'd0,
        RET_VIS  = 2'd1,
        RET_WRAP = 2'd2
    } t_ret;

    t_state        r_state, n_state;
    logic [1:0]    r_n, n_n;
    t_result       r_res0, n_res0, r_res1, n_res1;
    logic [7:0]    r_col, n_col;
    logic [7:0]    r_lc, n_lc;
    logic          r_wrap, n_wrap;
    logic          r_quit, n_quit;
    logic          r_await, n_await;
    logic [CW-1:0] r_pc, n_pc;
    logic          r_pe, n_pe;
    logic [7:0]    r_pb, n_pb;
    logic [7:0]    r_byte, n_byte;
    logic [CW-1:0] r_cells, n_cells;
    logic [7:0]    r_avail, n_avail;
    t_ret          r_ret, n_ret;

    logic          emit_en;
    t_result       emit_res;
    logic          accept;
    logic          prompt_hit;
    logic [7:0]    cells8;
    t_prompt       pfit;
    logic [17:0]   tab_prod;
    logic [7:0]    tab_quo;
    logic [15:0]   tab_base;
    logic [7:0]    tab_rem;

    assign accept  = i_req.valid && i_req.ready;
    assign pfit    = prompt_fit(i_cfg.screen_cols);

    // column modulo the tab stop by reciprocal multiply
    assign tab_prod = {10'd0, r_col} * 18'(TAB_MUL);
    assign tab_quo  = 8'(tab_prod >> TAB_SH);
    assign tab_base = {8'd0, tab_quo} * 16'(TAB_STOP);
    assign tab_rem  = r_col - tab_base[7:0];

    assign i_req.ready          = (r_state == S_IDLE);
    assign o_rsp.valid          = (r_state == S_OUT);
    assign o_rsp.kind           = r_res0.kind;
    assign o_rsp.echo_code      = r_res0.echo_code;
    assign o_rsp.prompt_choice  = r_res0.choice;
    assign o_rsp.prompt_chars   = r_res0.len;
    assign o_rsp.last           = (r_n == 2'd1);

    always_comb begin
        n_state  = r_state;
        n_n      = r_n;
        n_res0   = r_res0;
        n_res1   = r_res1;
        n_col    = r_col;
        n_lc     = r_lc;
        n_wrap   = r_wrap;
        n_quit   = r_quit;
        n_await  = r_await;
        n_pc     = r_pc;
        n_pe     = r_pe;
        n_pb     = r_pb;
        n_byte   = r_byte;
        n_cells  = r_cells;
        n_avail  = r_avail;
        n_ret    = r_ret;
        emit_en  = 1'b0;
        emit_res = '{kind: KIND_ECHO, echo_code: 8'd0, choice: 2'd0, len: 5'd0};
        o_alu    = '{a: 8'd0, b: 8'd0, sub: 1'b0};
        prompt_hit = 1'b0;
        cells8   = 8'd0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (r_quit || (!i_req.action && r_await) || (i_req.action && !r_await)) begin
                        emit_en       = 1'b1;
                        emit_res.kind = KIND_DROP;
                        n_state       = S_OUT;
                    end else if (i_req.action) begin
                        n_await = 1'b0;
                        n_lc    = 8'd0;
                        n_col   = 8'd0;
                        n_wrap  = 1'b0;
                        if (i_req.byte_code == CODE_Q_LO || i_req.byte_code == CODE_Q_UP) begin
                            n_quit  = 1'b1;
                            n_pe    = 1'b0;
                            n_pc    = '0;
                            n_pb    = 8'd0;
                            n_state = S_OUT;
                        end else if (r_pe) begin
                            n_pe               = 1'b0;
                            n_pb               = 8'd0;
                            n_pc               = '0;
                            emit_en            = 1'b1;
                            emit_res.echo_code = r_pb;
                            n_byte             = r_pb;
                            n_state            = S_CELLS;
                        end else if (r_pc != '0) begin
                            n_cells = r_pc;
                            n_pc    = '0;
                            if (i_cfg.paging_on && i_cfg.screen_cols != 8'd0) begin
                                n_state = S_W0;
                            end else begin
                                n_state = S_OUT;
                            end
                        end else begin
                            n_state = S_OUT;
                        end
                    end else if (i_req.byte_code == CODE_LF) begin
                        emit_en            = 1'b1;
                        emit_res.echo_code = i_req.byte_code;
                        if (i_cfg.paging_on) begin
                            n_col   = 8'd0;
                            n_wrap  = 1'b0;
                            n_ret   = RET_LINE;
                            n_state = S_LA;
                        end else begin
                            n_state = S_OUT;
                        end
                    end else if (i_req.byte_code == CODE_CR) begin
                        emit_en            = 1'b1;
                        emit_res.echo_code = i_req.byte_code;
                        if (i_cfg.paging_on) begin
                            n_col  = 8'd0;
                            n_wrap = 1'b0;
                        end
                        n_state = S_OUT;
                    end else begin
                        n_byte = i_req.byte_code;
                        if (i_cfg.paging_on && r_wrap) begin
                            n_col   = 8'd0;
                            n_wrap  = 1'b0;
                            n_ret   = RET_VIS;
                            n_state = S_LA;
                        end else begin
                            emit_en            = 1'b1;
                            emit_res.echo_code = i_req.byte_code;
                            n_state            = S_CELLS;
                        end
                    end
                end
            end
            S_LA: begin
                o_alu   = '{a: r_lc, b: 8'd1, sub: 1'b0};
                n_lc    = i_alu.sum;
                n_state = S_LB;
            end
            S_LB: begin
                o_alu      = '{a: r_lc, b: i_cfg.page_lines, sub: 1'b1};
                prompt_hit = (i_cfg.page_lines != 8'd0) && i_alu.carry;
                if (prompt_hit) begin
                    emit_en         = 1'b1;
                    emit_res.kind   = KIND_PROMPT;
                    emit_res.choice = pfit.choice;
                    emit_res.len    = pfit.len;
                    n_await         = 1'b1;
                end
                case (r_ret)
                    RET_LINE: begin
                        n_state = S_OUT;
                    end
                    RET_VIS: begin
                        if (prompt_hit) begin
                            n_pe    = 1'b1;
                            n_pb    = r_byte;
                            n_state = S_OUT;
                        end else begin
                            emit_en            = 1'b1;
                            emit_res.echo_code = r_byte;
                            n_state            = S_CELLS;
                        end
                    end
                    RET_WRAP: begin
                        if (prompt_hit) begin
                            n_pc    = r_cells;
                            n_state = S_OUT;
                        end else begin
                            n_state = S_W0;
                        end
                    end
                    default: begin
                        n_state = S_OUT;
                    end
                endcase
            end
            S_CELLS: begin
                if (r_byte == CODE_TAB) begin
                    cells8 = (i_cfg.screen_cols != 8'd0) ? 8'(TAB_STOP) - tab_rem
                                                         : 8'(TAB_STOP);
                end else if (r_byte >= CODE_SPACE && r_byte <= CODE_DEL) begin
                    cells8 = 8'd1;
                end
                n_cells = cells8[CW-1:0];
                if (!i_cfg.paging_on || cells8 == 8'd0 || i_cfg.screen_cols == 8'd0) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_W0;
                end
            end
            S_W0: begin
                o_alu = '{a: i_cfg.screen_cols, b: r_col, sub: 1'b1};
                if (!i_alu.carry || i_alu.sum == 8'd0) begin
                    n_col   = 8'd0;
                    n_wrap  = 1'b0;
                    n_ret   = RET_WRAP;
                    n_state = S_LA;
                end else begin
                    n_avail = i_alu.sum;
                    n_state = S_W2;
                end
            end
            S_W2: begin
                o_alu = '{a: 8'(r_cells), b: r_avail, sub: 1'b1};
                if (!i_alu.carry) begin
                    n_state = S_W3;
                end else begin
                    n_cells = i_alu.sum[CW-1:0];
                    if (i_alu.sum == 8'd0) begin
                        n_col   = i_cfg.screen_cols;
                        n_wrap  = 1'b1;
                        n_state = S_OUT;
                    end else begin
                        n_col   = 8'd0;
                        n_wrap  = 1'b0;
                        n_ret   = RET_WRAP;
                        n_state = S_LA;
                    end
                end
            end
            S_W3: begin
                o_alu   = '{a: r_col, b: 8'(r_cells), sub: 1'b0};
                n_col   = i_alu.sum;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (o_rsp.ready) begin
                    n_res0 = r_res1;
                    n_n    = r_n - 2'd1;
                    if (r_n == 2'd1) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (emit_en) begin
            if (r_n == 2'd0) begin
                n_res0 = emit_res;
            end else begin
                n_res1 = emit_res;
            end
            n_n = r_n + 2'd1;
        end

        // skip the result stage when the request produced nothing
        if (r_state != S_OUT && n_state == S_OUT && n_n == 2'd0) begin
            n_state = S_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_n     <= 2'd0;
            r_col   <= 8'd0;
            r_lc    <= 8'd0;
            r_wrap  <= 1'b0;
            r_quit  <= 1'b0;
            r_await <= 1'b0;
            r_pc    <= '0;
            r_pe    <= 1'b0;
            r_pb    <= 8'd0;
        end else begin
            r_state <= n_state;
            r_n     <= n_n;
            r_col   <= n_col;
            r_lc    <= n_lc;
            r_wrap  <= n_wrap;
            r_quit  <= n_quit;
            r_await <= n_await;
            r_pc    <= n_pc;
            r_pe    <= n_pe;
            r_pb    <= n_pb;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res0  <= n_res0;
        r_res1  <= n_res1;
        r_byte  <= n_byte;
        r_cells <= n_cells;
        r_avail <= n_avail;
        r_ret   <= n_ret;
    end
endmodule

// ----- src/terminal_wrap_pagination_tracker.sv -----
// Top level of the pager wrap tracker: configuration registers, sequencer and adder.
`timescale 1ns / 1ps
// Echoes output bytes and follows the cursor column and line count across the
// configured screen. When a page fills, a prompt result is issued and further
// bytes are dropped until a key request arrives; q or Q stops the stream for good.
// One request at a time: i_req.ready is high only while the block is idle, and
// the results of a request, at most two, are then offered on o_rsp in order, the
// final one flagged by last. After the accept, each operation is one step on the
// shared adder: a printable byte goes through the wrap steps S_W0, S_W2, S_W3, a
// line count through S_LA and S_LB, and a tab wrapping over several narrow lines
// repeats the wrap and line-count steps for each line crossed; S_OUT then offers each result.
module terminal_wrap_pagination_tracker #(
    parameter int TAB_STOP = twp_pkg::TAB_STOP_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data,
    twp_req_if.sink    i_req,
    twp_rsp_if.source  o_rsp
);
    import twp_pkg::*;

    t_cfg     r_cfg;
    t_alu_req alu_req;
    t_alu_rsp alu_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.page_lines  <= 8'd24;
            r_cfg.screen_cols <= COLS_DEFAULT;
            r_cfg.paging_on   <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PAGE_LINES:  r_cfg.page_lines  <= i_cfg_data;
                CFG_SCREEN_COLS: r_cfg.screen_cols <= i_cfg_data;
                CFG_PAGING_ON:   r_cfg.paging_on   <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    twp_alu u_alu (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    twp_seq #(
        .TAB_STOP (TAB_STOP)
    ) u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_req   (i_req),
        .o_rsp   (o_rsp),
        .o_alu   (alu_req),
        .i_alu   (alu_rsp)
    );
endmodule

// ----- src/twp_checker.sv -----
// Port-level checks for the pager wrap tracker, bound to the top level.
`timescale 1ns / 1ps
module twp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [1:0] i_kind,
    input logic [7:0] i_echo,
    input logic [1:0] i_choice,
    input logic [4:0] i_len,
    input logic       i_last
);
    import twp_pkg::*;

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_in_valid && i_in_ready))
        else $error("request taken while results pending");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_kind) && $stable(i_echo)
            && $stable(i_choice) && $stable(i_len) && $stable(i_last))
        else $error("stalled result changed");

    a_drop_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_kind == KIND_DROP |-> i_last)
        else $error("drop result not final");

    a_prompt_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_kind == KIND_PROMPT |->
            (i_choice == CHOICE_FULL && i_len == LEN_FULL) ||
            (i_choice == CHOICE_SHORT && i_len == LEN_SHORT) ||
            (i_choice == CHOICE_MINI && i_len == LEN_MINI) ||
            (i_choice == CHOICE_TINY && i_len == LEN_TINY))
        else $error("prompt choice and length disagree");

    a_follow_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_last |=> i_out_valid)
        else $error("non-final result without successor");
endmodule

bind terminal_wrap_pagination_tracker twp_checker u_twp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_kind      (o_rsp.kind),
    .i_echo      (o_rsp.echo_code),
    .i_choice    (o_rsp.prompt_choice),
    .i_len       (o_rsp.prompt_chars),
    .i_last      (o_rsp.last)
);
